// ----- hw/rtl/lomt_pkg.sv -----
package lomt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int PRICE_WIDTH_DEF = 32;
  localparam int MaxResults      = 16;

  localparam logic [1:0] CMD_SUBMIT = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [2:0] EV_REJECTED  = 3'd0;
  localparam logic [2:0] EV_FILLED    = 3'd1;
  localparam logic [2:0] EV_PENDING   = 3'd2;
  localparam logic [2:0] EV_CANCELLED = 3'd3;
  localparam logic [2:0] EV_NOT_FOUND = 3'd4;
  localparam logic [2:0] EV_FULL      = 3'd5;

  typedef struct packed {
    logic [1:0]         command;
    logic               is_market;
    logic               side;
    logic signed [31:0] limit_price;
    logic signed [31:0] market_price;
    logic [31:0]        quantity;
    logic [47:0]        time_ms;
    logic [31:0]        cancel_id;
  } ord_in_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [31:0]        ord_id;
    logic [31:0]        trade_num;
    logic               fill_side;
    logic signed [31:0] fill_price;
    logic [31:0]        fill_quantity;
    logic [47:0]        fill_time;
    logic               last;
  } ord_res_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } lomt_state_t;

endpackage

// ----- hw/rtl/lomt_ram.sv -----
module lomt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // hold read data while no read is issued
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/limit_order_match_table.sv -----
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready   | in_data  (lomt_pkg::ord_in_t)
// out_    | output    | out_valid / out_ready | out_data (lomt_pkg::ord_res_t)
//
// Submit: its result goes to the hold register and leaves through the output register.
// Cancel and tick: the table RAM is read and written back one entry per cycle, unless
//   the scan is paused, compacting as orders leave.
// A scan pauses on a fill or cancel while the hold register is full and the output
//   register holds an untaken result; results leave in order, last set on the final one.
// Reset clears the fill count, id counter and control; the table RAM needs no clearing.
module limit_order_match_table #(
  parameter int TABLE_DEPTH = lomt_pkg::TABLE_DEPTH_DEF,
  parameter int PRICE_WIDTH = lomt_pkg::PRICE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lomt_pkg::ord_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lomt_pkg::ord_res_t out_data
);

  import lomt_pkg::*;

  localparam int PwEff = (PRICE_WIDTH < 32) ? PRICE_WIDTH : 32;
  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int EW    = 65 + PwEff;
  localparam int FW    = $clog2(MaxResults + 1);

  lomt_state_t state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [31:0]             id_r, id_nxt;
  logic [AW-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]           end_ptr_r, end_ptr_nxt;
  logic                    found_r, found_nxt;
  logic [FW-1:0]           fills_r, fills_nxt;
  logic [1:0]              cmd_r, cmd_nxt;
  logic signed [PwEff-1:0] mp_r, mp_nxt;
  logic [47:0]             time_r, time_nxt;
  logic [31:0]             cid_r, cid_nxt;
  logic                    hold_valid_r, hold_valid_nxt;
  ord_res_t                hold_r, hold_nxt;
  logic                    out_valid_r, out_valid_nxt;
  ord_res_t                out_r, out_nxt;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_wa, ram_ra;
  logic [EW-1:0]           ram_wd, ram_rd;

  logic signed [PwEff-1:0] in_lim, in_mp, ent_lim;
  logic [31:0]             ent_id, ent_qty;
  logic                    ent_side;
  logic                    out_free, can_take, drop, advance;

  function automatic logic qual(input logic sd, input logic signed [PwEff-1:0] p,
                                input logic signed [PwEff-1:0] l);
    return sd ? (p >= l) : (p <= l);
  endfunction

  function automatic ord_res_t mk_res(input logic [2:0] ev, input logic [31:0] oid,
                                      input logic [31:0] tno, input logic sd,
                                      input logic signed [31:0] price,
                                      input logic [31:0] qty, input logic [47:0] t);
    ord_res_t r;
    r.event_res     = ev;
    r.ord_id        = oid;
    r.trade_num     = tno;
    r.fill_side     = sd;
    r.fill_price    = price;
    r.fill_quantity = qty;
    r.fill_time     = t;
    r.last          = 1'b0;
    return r;
  endfunction

  lomt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign in_lim   = in_data.limit_price[PwEff-1:0];
  assign in_mp    = in_data.market_price[PwEff-1:0];
  assign ent_id   = ram_rd[EW-1 -: 32];
  assign ent_side = ram_rd[PwEff+32];
  assign ent_lim  = ram_rd[PwEff+31:32];
  assign ent_qty  = ram_rd[31:0];

  assign out_free = !out_valid_r || out_ready;
  assign can_take = !hold_valid_r || out_free;
  assign drop     = (cmd_r == CMD_CANCEL) ? (!found_r && (ent_id == cid_r))
                  : ((fills_r < FW'(MaxResults)) && qual(ent_side, mp_r, ent_lim));
  assign advance  = !drop || can_take;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    id_nxt         = id_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    end_ptr_nxt    = end_ptr_r;
    found_nxt      = found_r;
    fills_nxt      = fills_r;
    cmd_nxt        = cmd_r;
    mp_nxt         = mp_r;
    time_nxt       = time_r;
    cid_nxt        = cid_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_wa         = wr_ptr_r;
    ram_wd         = ram_rd;
    ram_re         = 1'b0;
    ram_ra         = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_data.command;
          mp_nxt      = in_mp;
          time_nxt    = in_data.time_ms;
          cid_nxt     = in_data.cancel_id;
          found_nxt   = 1'b0;
          fills_nxt   = '0;
          rd_ptr_nxt  = '0;
          wr_ptr_nxt  = '0;
          end_ptr_nxt = AW'(count_r - CW'(1));
          case (in_data.command)
            CMD_SUBMIT: begin
              hold_valid_nxt = 1'b1;
              state_nxt      = ST_FLUSH;
              id_nxt         = id_r + 32'd1;
              if (in_data.is_market) begin
                if (in_mp <= 0) begin
                  hold_nxt = mk_res(EV_REJECTED, id_r + 32'd1, '0, in_data.side, '0, '0,
                                    in_data.time_ms);
                end else begin
                  id_nxt   = id_r + 32'd2;
                  hold_nxt = mk_res(EV_FILLED, id_r + 32'd1, id_r + 32'd2, in_data.side,
                                    32'(in_mp), in_data.quantity, in_data.time_ms);
                end
              end else if (qual(in_data.side, in_mp, in_lim)) begin
                id_nxt   = id_r + 32'd2;
                hold_nxt = mk_res(EV_FILLED, id_r + 32'd1, id_r + 32'd2, in_data.side,
                                  32'(in_lim), in_data.quantity, in_data.time_ms);
              end else if (count_r == CW'(TABLE_DEPTH)) begin
                hold_nxt = mk_res(EV_FULL, id_r + 32'd1, '0, in_data.side, 32'(in_lim),
                                  in_data.quantity, in_data.time_ms);
              end else begin
                // append at the fill count
                ram_we    = 1'b1;
                ram_wa    = count_r[AW-1:0];
                ram_wd    = {id_r + 32'd1, in_data.side, in_lim, in_data.quantity};
                count_nxt = count_r + CW'(1);
                hold_nxt  = mk_res(EV_PENDING, id_r + 32'd1, '0, in_data.side, 32'(in_lim),
                                   in_data.quantity, in_data.time_ms);
              end
            end
            CMD_CANCEL: begin
              if (count_r == '0) begin
                hold_valid_nxt = 1'b1;
                hold_nxt       = mk_res(EV_NOT_FOUND, in_data.cancel_id, '0, 1'b0, '0, '0,
                                        in_data.time_ms);
                state_nxt      = ST_FLUSH;
              end else begin
                ram_re    = 1'b1;
                state_nxt = ST_SCAN;
              end
            end
            CMD_TICK: begin
              if (count_r == '0) begin
                state_nxt = ST_FLUSH;
              end else begin
                ram_re    = 1'b1;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (drop && can_take) begin
          if (hold_valid_r) begin
            out_nxt       = hold_r;
            out_valid_nxt = 1'b1;
          end
          hold_valid_nxt = 1'b1;
          count_nxt      = count_r - CW'(1);
          if (cmd_r == CMD_CANCEL) begin
            found_nxt = 1'b1;
            hold_nxt  = mk_res(EV_CANCELLED, cid_r, '0, ent_side, 32'(ent_lim), ent_qty,
                               time_r);
          end else begin
            id_nxt    = id_r + 32'd1;
            fills_nxt = fills_r + FW'(1);
            hold_nxt  = mk_res(EV_FILLED, ent_id, id_r + 32'd1, ent_side, 32'(ent_lim),
                               ent_qty, time_r);
          end
        end else if (!drop) begin
          // keep: write the entry back at the compacted position
          ram_we     = 1'b1;
          wr_ptr_nxt = wr_ptr_r + AW'(1);
        end
        if (advance) begin
          if (rd_ptr_r == end_ptr_r) begin
            state_nxt = ST_FLUSH;
            if (cmd_r == CMD_CANCEL && !found_nxt) begin
              hold_valid_nxt = 1'b1;
              hold_nxt       = mk_res(EV_NOT_FOUND, cid_r, '0, 1'b0, '0, '0, time_r);
            end
          end else begin
            ram_re     = 1'b1;
            ram_ra     = rd_ptr_r + AW'(1);
            rd_ptr_nxt = rd_ptr_r + AW'(1);
          end
        end
      end

      ST_FLUSH: begin
        if (!hold_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_nxt        = hold_r;
          out_nxt.last   = 1'b1;
          out_valid_nxt  = 1'b1;
          hold_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      id_r         <= '0;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      end_ptr_r    <= '0;
      found_r      <= 1'b0;
      fills_r      <= '0;
      cmd_r        <= CMD_SUBMIT;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      id_r         <= id_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      end_ptr_r    <= end_ptr_nxt;
      found_r      <= found_nxt;
      fills_r      <= fills_nxt;
      cmd_r        <= cmd_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mp_r   <= mp_nxt;
    time_r <= time_nxt;
    cid_r  <= cid_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !hold_valid_r)
    else $error("hold register occupied while idle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("fill count exceeds table depth");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (wr_ptr_r <= rd_ptr_r))
    else $error("write-back pointer passed read pointer");

  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fills_r <= FW'(MaxResults))
    else $error("fills per tick exceed cap");
`endif

endmodule
